[rtl/gds_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gds_pkg
// shared types and constants of the gaussian density scorer
// ----------------------------------------------------------------------------
package gds_pkg;

    localparam int N_CODEBOOKS   = 8;
    localparam int N_STREAMS     = 4;
    localparam int MAX_DENSITIES = 64;
    localparam int MAX_DIM       = 64;

    localparam logic [2:0] MODE_LOAD_MV   = 3'd0;
    localparam logic [2:0] MODE_LOAD_NORM = 3'd1;
    localparam logic [2:0] MODE_LOAD_OBS  = 3'd2;
    localparam logic [2:0] MODE_SCORE_ALL = 3'd3;
    localparam logic [2:0] MODE_SCORE_SEL = 3'd4;

    localparam logic [2:0] CFG_DENSITY_COUNT = 3'd0;
    localparam logic [2:0] CFG_VEC_LEN0      = 3'd1;
    localparam logic [2:0] CFG_VEC_LEN3      = 3'd4;

    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;
    localparam logic signed [6:0]  IDX_NONE = -7'sd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_DIM,
        ST_DRAIN,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic start;      // latch item fields, reset mode-4 list if asked
        logic den_load;   // begin a density: clear dimension counter
        logic acc_init;   // load accumulator from norm
        logic dim_issue;  // issue element read for current dim
        logic acc_step;   // subtract registered term
        logic emit;       // result taken: advance density
        logic finish;     // update best trackers and result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic dim_more;   // another dimension remains and score above bound
        logic den_more;   // another density remains
        logic pipe_busy;  // terms still in flight
        logic is_sel;
    } t_stat;

endpackage

[rtl/gaussian_density_scorer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_density_scorer_top
// diagonal gaussian log-likelihood scorer with parameter tables
// ----------------------------------------------------------------------------
// loads are accepted while idle and give no result
// a density walks its dimensions one term at a time (memory read, two
// multiply stages, accumulate are serialized for the early-stop check),
// then its result is held in the output register until taken
// one result per density, one item at a time
// synchronous active-low reset clears control and trackers, sets config defaults, tables undefined
module gaussian_density_scorer_top
    import gds_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [6:0]         i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_mode,
    input  logic [2:0]         i_codebook,
    input  logic [1:0]         i_stream,
    input  logic [5:0]         i_density,
    input  logic [5:0]         i_dimension,
    input  logic signed [31:0] i_value_a,
    input  logic [15:0]        i_value_b,
    input  logic signed [31:0] i_worst_bound,
    input  logic               i_first_of_list,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_score,
    output logic signed [6:0]  o_best_index,
    output logic               o_last
);

    t_cmd  cmd;
    t_stat stat;
    logic  acc;

    gds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_mode      (i_mode),
        .o_stall     (o_stall),
        .i_out_stall (i_stall),
        .o_valid     (o_valid),
        .o_acc       (acc),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    gds_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_acc           (acc),
        .i_mode          (i_mode),
        .i_codebook      (i_codebook),
        .i_stream        (i_stream),
        .i_density       (i_density),
        .i_dimension     (i_dimension),
        .i_value_a       (i_value_a),
        .i_value_b       (i_value_b),
        .i_worst_bound   (i_worst_bound),
        .i_first_of_list (i_first_of_list),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_score         (o_score),
        .o_best_index    (o_best_index),
        .o_last          (o_last)
    );

endmodule

[rtl/gds_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gds_datapath
// parameter memories, multiply-accumulate pipeline and best-index tracking
// ----------------------------------------------------------------------------
module gds_datapath
    import gds_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [6:0]         i_cfg_data,
    input  logic               i_acc,
    input  logic [2:0]         i_mode,
    input  logic [2:0]         i_codebook,
    input  logic [1:0]         i_stream,
    input  logic [5:0]         i_density,
    input  logic [5:0]         i_dimension,
    input  logic signed [31:0] i_value_a,
    input  logic [15:0]        i_value_b,
    input  logic signed [31:0] i_worst_bound,
    input  logic               i_first_of_list,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    output logic signed [31:0] o_score,
    output logic signed [6:0]  o_best_index,
    output logic               o_last
);

    localparam int CBW = (N_CODEBOOKS > 1) ? $clog2(N_CODEBOOKS) : 1;
    localparam int STW = (N_STREAMS > 1) ? $clog2(N_STREAMS) : 1;
    localparam int DNW = (MAX_DENSITIES > 1) ? $clog2(MAX_DENSITIES) : 1;
    localparam int DMW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int NDEPTH = N_CODEBOOKS * N_STREAMS * MAX_DENSITIES;
    localparam int EDEPTH = NDEPTH * MAX_DIM;
    localparam int ODEPTH = N_STREAMS * MAX_DIM;
    localparam int NAW = (NDEPTH > 1) ? $clog2(NDEPTH) : 1;
    localparam int EAW = (EDEPTH > 1) ? $clog2(EDEPTH) : 1;
    localparam int OAW = (ODEPTH > 1) ? $clog2(ODEPTH) : 1;

    logic [15:0] mem_mean [EDEPTH];
    logic [15:0] mem_ivar [EDEPTH];
    logic [31:0] mem_norm [NDEPTH];
    logic [15:0] mem_obs  [ODEPTH];

    logic [6:0] r_dcount;
    logic [6:0] r_vlen [4];

    logic [CBW-1:0] r_cb;
    logic [STW-1:0] r_st;
    logic [DNW-1:0] r_den;
    logic [6:0]     r_dim;
    logic [6:0]     r_len;
    logic [6:0]     r_n;
    logic           r_sel;
    logic signed [32:0] r_worst;

    logic signed [32:0] r_acc;
    logic [15:0] r_mean, r_ivar, r_obs;
    logic [31:0] r_norm;
    logic        r_v1, r_v2, r_v3;
    logic [33:0] r_sq;
    logic [15:0] r_ivar2;
    logic [15:0] r_term;

    logic signed [31:0] r_best;
    logic signed [6:0]  r_arg;
    logic signed [31:0] r_rmin;
    logic signed [6:0]  r_rarg;
    logic [5:0]         r_lpos;

    logic [6:0]         r_o_best;
    logic signed [31:0] r_o_score;
    logic               r_o_last;

    // clamped scoring indexes and lengths
    logic [CBW-1:0] cb_sat;
    logic [STW-1:0] st_sat;
    logic [DNW-1:0] den_sat;
    logic [6:0]     vlen_sel;
    logic [6:0]     len_c;
    logic [6:0]     n_c;
    logic [NAW-1:0] nidx;
    logic [EAW-1:0] eidx;
    logic           ok_cs;
    logic signed [16:0] diff;
    logic signed [33:0] diff_sq;
    logic [49:0]        prod;
    logic signed [32:0] acc_sub;
    logic               last_den;

    always_comb begin
        cb_sat  = (32'(i_codebook) >= N_CODEBOOKS) ? CBW'(N_CODEBOOKS - 1) : CBW'(i_codebook);
        st_sat  = (32'(i_stream) >= N_STREAMS) ? STW'(N_STREAMS - 1) : STW'(i_stream);
        den_sat = (32'(i_density) >= MAX_DENSITIES) ? DNW'(MAX_DENSITIES - 1)
                                                    : DNW'(i_density);
        vlen_sel = r_vlen[2'(st_sat)];
        len_c = (vlen_sel == 7'd0) ? 7'd1
              : ((32'(vlen_sel) > MAX_DIM) ? 7'(MAX_DIM) : vlen_sel);
        n_c = (r_dcount == 7'd0) ? 7'd1
            : ((32'(r_dcount) > MAX_DENSITIES) ? 7'(MAX_DENSITIES) : r_dcount);
        ok_cs = (32'(i_codebook) < N_CODEBOOKS) && (32'(i_stream) < N_STREAMS);
        nidx = NAW'((32'(r_cb) * N_STREAMS + 32'(r_st)) * MAX_DENSITIES + 32'(r_den));
        eidx = EAW'(32'(nidx) * MAX_DIM + 32'(r_dim[DMW-1:0]));
        diff = 17'(signed'(r_obs)) - 17'(signed'(r_mean));
        last_den = (7'(r_den) + 7'd1 >= r_n);
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcount <= 7'd64;
            for (int k = 0; k < 4; k++) r_vlen[k] <= 7'd13;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_DENSITY_COUNT) begin
                r_dcount <= i_cfg_data;
            end else if (i_cfg_index >= CFG_VEC_LEN0 && i_cfg_index <= CFG_VEC_LEN3) begin
                r_vlen[2'(i_cfg_index - CFG_VEC_LEN0)] <= i_cfg_data;
            end
        end
    end

    // table writes
    always_ff @(posedge i_clk) begin
        if (i_acc && i_mode == MODE_LOAD_MV && ok_cs && 32'(i_density) < MAX_DENSITIES
                && 32'(i_dimension) < MAX_DIM) begin
            mem_mean[EAW'(((32'(i_codebook) * N_STREAMS + 32'(i_stream)) * MAX_DENSITIES
                     + 32'(i_density)) * MAX_DIM + 32'(i_dimension))] <= i_value_a[15:0];
            mem_ivar[EAW'(((32'(i_codebook) * N_STREAMS + 32'(i_stream)) * MAX_DENSITIES
                     + 32'(i_density)) * MAX_DIM + 32'(i_dimension))] <= i_value_b;
        end
        if (i_acc && i_mode == MODE_LOAD_NORM && ok_cs && 32'(i_density) < MAX_DENSITIES) begin
            mem_norm[NAW'((32'(i_codebook) * N_STREAMS + 32'(i_stream)) * MAX_DENSITIES
                     + 32'(i_density))] <= i_value_a;
        end
        if (i_acc && i_mode == MODE_LOAD_OBS && 32'(i_stream) < N_STREAMS
                && 32'(i_dimension) < MAX_DIM) begin
            mem_obs[OAW'(32'(i_stream) * MAX_DIM + 32'(i_dimension))] <= i_value_a[15:0];
        end
    end

    // table reads
    always_ff @(posedge i_clk) begin
        r_norm <= mem_norm[nidx];
        r_mean <= mem_mean[eidx];
        r_ivar <= mem_ivar[eidx];
        r_obs  <= mem_obs[OAW'(32'(r_st) * MAX_DIM + 32'(r_dim[DMW-1:0]))];
    end

    // item fields and walk counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_cb    <= cb_sat;
            r_st    <= st_sat;
            r_len   <= len_c;
            r_n     <= n_c;
            r_sel   <= (i_mode == MODE_SCORE_SEL);
            r_den   <= (i_mode == MODE_SCORE_SEL) ? den_sat : '0;
            r_worst <= (i_mode == MODE_SCORE_SEL) ? 33'(INT_MIN) : 33'(i_worst_bound);
        end else if (i_cmd.emit && !r_sel && !last_den) begin
            r_den <= r_den + 1'b1;
        end
        if (i_cmd.den_load) begin
            r_dim <= '0;
        end else if (i_cmd.dim_issue) begin
            r_dim <= r_dim + 7'd1;
        end
    end

    // multiply pipeline: diff^2 then times invvar
    always_comb begin
        diff_sq = diff * diff;
        prod    = r_sq[31:0] * r_ivar2;
        acc_sub = r_acc - 33'(r_term);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.dim_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_sq    <= 34'(diff_sq);
        r_ivar2 <= r_ivar;
        r_term  <= prod[47:32];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_init) begin
            r_acc <= 33'(signed'(r_norm));
        end else if (i_cmd.acc_step && r_v3) begin
            r_acc <= (acc_sub < 33'(INT_MIN)) ? 33'(INT_MIN) : acc_sub;
        end
    end

    // best trackers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rmin <= INT_MAX;
            r_rarg <= IDX_NONE;
            r_lpos <= '0;
            r_best <= INT_MIN;
            r_arg  <= IDX_NONE;
        end else begin
            if (i_cmd.start) begin
                r_best <= INT_MIN;
                r_arg  <= IDX_NONE;
                if (i_mode == MODE_SCORE_SEL && i_first_of_list) begin
                    r_rmin <= INT_MAX;
                    r_rarg <= IDX_NONE;
                    r_lpos <= '0;
                end
            end
            if (i_cmd.finish) begin
                if (r_sel) begin
                    if (32'(r_acc) < r_rmin) begin
                        r_rmin <= 32'(r_acc);
                        r_rarg <= 7'(r_lpos);
                    end
                    if (r_lpos != 6'd63) r_lpos <= r_lpos + 6'd1;
                end else if (32'(r_acc) > r_best) begin
                    r_best <= 32'(r_acc);
                    r_arg  <= 7'(r_den);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_o_score <= 32'(r_acc);
            if (r_sel) begin
                r_o_last <= 1'b1;
                r_o_best <= (32'(r_acc) < r_rmin) ? 7'(r_lpos) : r_rarg;
            end else begin
                r_o_last <= last_den;
                r_o_best <= !last_den ? IDX_NONE
                          : ((32'(r_acc) > r_best) ? 7'(r_den) : r_arg);
            end
        end
    end

    assign o_stat.dim_more  = (r_dim < r_len) && (r_acc > r_worst);
    assign o_stat.den_more  = !r_sel && !last_den;
    assign o_stat.pipe_busy = r_v1 || r_v2 || r_v3;
    assign o_stat.is_sel    = r_sel;
    assign o_score      = r_o_score;
    assign o_best_index = r_o_best;
    assign o_last       = r_o_last;

endmodule

[rtl/gds_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gds_ctrl
// sequencer over densities and dimensions plus output handshake
// ----------------------------------------------------------------------------
module gds_ctrl
    import gds_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [2:0] i_mode,
    output logic       o_stall,
    input  logic       i_out_stall,
    output logic       o_valid,
    output logic       o_acc,
    input  t_stat      i_stat,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;
    logic   r_busy_seen;
    logic   is_score;

    assign is_score = (i_mode == MODE_SCORE_ALL) || (i_mode == MODE_SCORE_SEL);
    assign o_acc    = i_valid && !o_stall;

    // early stop: the bound is checked before each issue; once a term is in
    // flight the next check waits until it lands
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (o_acc && is_score) n_state = ST_NORM;
            ST_NORM:  n_state = ST_DIM;
            ST_DIM: begin
                if (r_busy_seen && !i_stat.pipe_busy && !i_stat.dim_more) n_state = ST_OUT;
            end
            ST_DRAIN: n_state = ST_DIM;
            ST_OUT:   if (!i_out_stall) n_state = i_stat.den_more ? ST_NORM : ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_stall = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                o_cmd.start = o_acc && is_score;
            end
            ST_NORM: begin
                o_cmd.den_load = 1'b1;
            end
            ST_DIM: begin
                o_cmd.acc_init  = !r_busy_seen;
                o_cmd.acc_step  = r_busy_seen;
                o_cmd.dim_issue = r_busy_seen && !i_stat.pipe_busy && i_stat.dim_more;
                if (!r_busy_seen) o_cmd.dim_issue = 1'b0;
                o_cmd.finish = !i_stat.pipe_busy && !i_stat.dim_more && r_busy_seen;
            end
            ST_OUT: begin
                o_valid = 1'b1;
                o_cmd.emit = !i_out_stall;
                o_cmd.den_load = !i_out_stall && i_stat.den_more;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy_seen <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DIM) r_busy_seen <= 1'b1;
            else r_busy_seen <= 1'b0;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_out_stall |=> o_valid) else $error("result dropped under stall");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> o_stall) else $error("item taken while busy");
    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> !i_stat.pipe_busy) else $error("finish with terms in flight");

endmodule
